/* hw/rtl/aessb_pkg.sv */
// ----------------------------------------------------------------------------
// aessb_pkg
// GF(2^8) arithmetic and AES affine transforms shared by the S-box pipeline.
// ----------------------------------------------------------------------------
package aessb_pkg;

  localparam logic [7:0] RED_LOW   = 8'h1B;  // x^4+x^3+x+1
  localparam logic [7:0] FWD_CONST = 8'h63;
  localparam logic [7:0] INV_CONST = 8'h05;

  localparam logic ACT_FWD = 1'b0;
  localparam logic ACT_INV = 1'b1;

  function automatic logic [7:0] xtime(input logic [7:0] x);
    xtime = {x[6:0], 1'b0} ^ (x[7] ? RED_LOW : 8'h00);
  endfunction

  // shift-and-add multiply, eight narrow steps
  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = xtime(x);
    end
    gf_mul = acc;
  endfunction

  function automatic logic [7:0] gf_sq(input logic [7:0] a);
    gf_sq = gf_mul(a, a);
  endfunction

  function automatic logic [7:0] affine_fwd(input logic [7:0] b);
    affine_fwd = b ^ {b[6:0], b[7]} ^ {b[5:0], b[7:6]} ^ {b[4:0], b[7:5]}
               ^ {b[3:0], b[7:4]} ^ FWD_CONST;
  endfunction

  function automatic logic [7:0] affine_inv(input logic [7:0] b);
    affine_inv = {b[6:0], b[7]} ^ {b[4:0], b[7:5]} ^ {b[1:0], b[7:2]} ^ INV_CONST;
  endfunction

endpackage

/* hw/rtl/aessb_in_if.sv */
// ----------------------------------------------------------------------------
// aessb_in_if
// Request channel into the S-box: direction bit and byte.
// ----------------------------------------------------------------------------
interface aessb_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_in;

  modport source (output valid, output action, output data_in, input ready);
  modport sink   (input valid, input action, input data_in, output ready);
endinterface

/* hw/rtl/aessb_out_if.sv */
// ----------------------------------------------------------------------------
// aessb_out_if
// Result channel out of the S-box: substituted byte.
// ----------------------------------------------------------------------------
interface aessb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_out;

  modport source (output valid, output data_out, input ready);
  modport sink   (input valid, input data_out, output ready);
endinterface

/* hw/rtl/aessb_datapath.sv */
// ----------------------------------------------------------------------------
// aessb_datapath
// Three-stage S-box datapath: a^254 by addition chain, affine on either side.
// ----------------------------------------------------------------------------
module aessb_datapath (
  input  logic       clk,
  input  logic       en,
  input  logic       action,
  input  logic [7:0] data_in,
  output logic [7:0] data_out
);
  import aessb_pkg::*;

  // stage 1: pre-affine, a and a^3
  logic [7:0] a1_r, a1_nxt;
  logic [7:0] a3_r, a3_nxt;
  logic       act1_r;
  // stage 2: a^14, a^15
  logic [7:0] a14_r, a14_nxt;
  logic [7:0] a15_r, a15_nxt;
  logic       act2_r;
  // stage 3: a^254 = a^240 * a^14, post-affine
  logic [7:0] out_r, out_nxt;

  logic [7:0] a12;
  logic [7:0] a240;
  logic [7:0] inv;

  always_comb begin
    a1_nxt = (action == ACT_INV) ? affine_inv(data_in) : data_in;
    a3_nxt = gf_mul(gf_sq(a1_nxt), a1_nxt);
  end

  always_comb begin
    a12     = gf_sq(gf_sq(a3_r));
    a14_nxt = gf_mul(a12, gf_sq(a1_r));
    a15_nxt = gf_mul(a12, a3_r);
  end

  always_comb begin
    a240    = gf_sq(gf_sq(gf_sq(gf_sq(a15_r))));
    inv     = gf_mul(a240, a14_r);
    out_nxt = (act2_r == ACT_INV) ? inv : affine_fwd(inv);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1_r   <= a1_nxt;
      a3_r   <= a3_nxt;
      act1_r <= action;
      a14_r  <= a14_nxt;
      a15_r  <= a15_nxt;
      act2_r <= act1_r;
      out_r  <= out_nxt;
    end
  end

  assign data_out = out_r;

endmodule

/* hw/rtl/aes_sbox_forward_inverse_unit.sv */
// ----------------------------------------------------------------------------
// aes_sbox_forward_inverse_unit
// Forward / inverse AES S-box, one byte per cycle unless out_chan stalls, three pipeline stages.
// ----------------------------------------------------------------------------
// Usage:
//   in_chan  : request with action (0 forward, 1 inverse) and data_in.
//   out_chan : substituted byte on data_out.
//   Both channels use valid/ready; a transfer happens when both are high.
//   The field inverse is an addition chain to a^254 split over three
//   register stages, with the affine transforms folded into the first and
//   last.
//   Throughput is one request per cycle while out_chan.ready stays high.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and in_chan.ready drops; empty stages behind the stalled result
//   hold as well, so bubbles are not squeezed out during a stall.
//   Reset (rst_n low, synchronous) empties the pipeline; no state besides
//   the stage valid bits.
// ----------------------------------------------------------------------------
module aes_sbox_forward_inverse_unit (
  input  logic        clk,
  input  logic        rst_n,
  aessb_in_if.sink    in_chan,
  aessb_out_if.source out_chan
);
  import aessb_pkg::*;

  localparam int STAGES = 3;

  logic [STAGES-1:0] vld_r, vld_nxt;
  logic              adv;

  // a stage moves when the last one is empty or being drained
  assign adv     = !vld_r[STAGES-1] || out_chan.ready;
  assign vld_nxt = {vld_r[STAGES-2:0], in_chan.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= vld_nxt;
    end
  end

  aessb_datapath u_dp (
    .clk      (clk),
    .en       (adv),
    .action   (in_chan.action),
    .data_in  (in_chan.data_in),
    .data_out (out_chan.data_out)
  );

  assign in_chan.ready  = adv;
  assign out_chan.valid = vld_r[STAGES-1];

  logic in_acc;
  assign in_acc = in_chan.valid && in_chan.ready;

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_chan.valid)
    else $error("pipeline not empty after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("valid bits moved during stall");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc ##1 adv ##1 adv) |=> out_chan.valid)
    else $error("request did not reach output after three advances");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !in_chan.valid ##1 adv ##1 adv) |=> !out_chan.valid)
    else $error("result appeared without a request");

endmodule

/* tb/tb_aes_sbox_forward_inverse_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_aes_sbox_forward_inverse_unit
// Checks the forward and inverse AES S-box against a bytewise predictor.
// A table of directed bytes, some with known S-box entries, comes first. Random requests follow under
// three idle patterns. Every substituted byte is compared in order with the
// byte predicted when its request was accepted.
// ----------------------------------------------------------------------------
module tb_aes_sbox_forward_inverse_unit;
  import aessb_pkg::*;

  localparam int          CLK_HALF     = 6;
  localparam int          RESET_CYCLES = 7;
  localparam int          RANDOM_ITEMS = 900;
  localparam int          STALL_LIMIT  = 1000;
  localparam int          DRAIN_CYCLES = 8;
  localparam logic [7:0]  POLY_LOW     = 8'h1B;
  localparam logic [7:0]  FWD_OFFSET   = 8'h63;
  localparam logic [7:0]  INV_OFFSET   = 8'h05;

  typedef struct packed {
    logic       act;
    logic [7:0] din;
    logic       fixed;
    logic [7:0] want;
  } sbox_row_t;

  localparam int N_ROWS = 24;
  // rows with fixed set carry a known S-box entry; the rest use the predictor
  localparam sbox_row_t DIRECTED [N_ROWS] = '{
    '{ACT_FWD, 8'h00, 1'b1, 8'h63},  // zero byte maps to zero before affine
    '{ACT_FWD, 8'h01, 1'b1, 8'h7C},  // unit byte is its own inverse
    '{ACT_FWD, 8'hFF, 1'b1, 8'h16},
    '{ACT_FWD, 8'h80, 1'b1, 8'hCD},
    '{ACT_FWD, 8'h7F, 1'b1, 8'hD2},
    '{ACT_FWD, 8'h53, 1'b1, 8'hED},
    '{ACT_INV, 8'h63, 1'b1, 8'h00},  // inverse of the zero case
    '{ACT_INV, 8'h7C, 1'b1, 8'h01},
    '{ACT_INV, 8'h16, 1'b1, 8'hFF},
    '{ACT_INV, 8'h00, 1'b1, 8'h52},
    '{ACT_INV, 8'hFF, 1'b1, 8'h7D},
    '{ACT_INV, 8'hED, 1'b1, 8'h53},
    '{ACT_FWD, 8'h02, 1'b0, 8'h00},
    '{ACT_FWD, 8'h04, 1'b0, 8'h00},
    '{ACT_FWD, 8'h08, 1'b0, 8'h00},
    '{ACT_FWD, 8'h10, 1'b0, 8'h00},
    '{ACT_FWD, 8'h20, 1'b0, 8'h00},
    '{ACT_FWD, 8'h40, 1'b0, 8'h00},
    '{ACT_FWD, 8'h55, 1'b0, 8'h00},
    '{ACT_FWD, 8'hAA, 1'b0, 8'h00},
    '{ACT_INV, 8'h01, 1'b0, 8'h00},
    '{ACT_INV, 8'h80, 1'b0, 8'h00},
    '{ACT_INV, 8'h55, 1'b0, 8'h00},
    '{ACT_INV, 8'hAA, 1'b0, 8'h00}
  };

  logic clk;
  logic rst_n;
  logic fixed_valid;
  logic [7:0] fixed_byte;

  int send_gap_pct;
  int stall_pct;
  int mismatches;
  int quiet_cycles;

  logic [7:0] sbox_bytes_due [$];

  aessb_in_if  req_if ();
  aessb_out_if sub_if ();

  aes_sbox_forward_inverse_unit dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (req_if),
    .out_chan (sub_if)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  function automatic logic [7:0] field_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] prod;
    logic [7:0] sh;
    prod = 8'h00;
    sh   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) prod = prod ^ sh;
      sh = {sh[6:0], 1'b0} ^ (sh[7] ? POLY_LOW : 8'h00);
    end
    return prod;
  endfunction

  // a^254: the inverse for nonzero a, zero for zero
  function automatic logic [7:0] field_inv(input logic [7:0] a);
    logic [7:0] acc;
    acc = 8'h01;
    for (int k = 0; k < 254; k++) acc = field_mul(acc, a);
    return acc;
  endfunction

  function automatic logic [7:0] rotl(input logic [7:0] b, input int k);
    return (b << k) | (b >> (8 - k));
  endfunction

  function automatic logic [7:0] aes_substitute(input logic act, input logic [7:0] b);
    logic [7:0] t;
    if (act == ACT_FWD) begin
      t = field_inv(b);
      return t ^ rotl(t, 1) ^ rotl(t, 2) ^ rotl(t, 3) ^ rotl(t, 4) ^ FWD_OFFSET;
    end else begin
      t = rotl(b, 1) ^ rotl(b, 3) ^ rotl(b, 6) ^ INV_OFFSET;
      return field_inv(t);
    end
  endfunction

  task automatic offer_request(input logic act, input logic [7:0] din,
                               input logic fixed, input logic [7:0] want);
    while ($urandom_range(99) < send_gap_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid   <= 1'b1;
    req_if.action  <= act;
    req_if.data_in <= din;
    fixed_valid    <= fixed;
    fixed_byte     <= want;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    sub_if.ready <= ($urandom_range(99) >= stall_pct);
  end

  // result check first, then log the accepted request
  always @(posedge clk) begin
    logic [7:0] want;
    if (rst_n && sub_if.valid && sub_if.ready) begin
      if (sbox_bytes_due.size() == 0) begin
        $display("%0t: unexpected result %02h", $time, sub_if.data_out);
        mismatches++;
      end else begin
        want = sbox_bytes_due.pop_front();
        if (sub_if.data_out !== want) begin
          $display("%0t: data_out expected %02h actual %02h", $time, want,
                   sub_if.data_out);
          mismatches++;
        end
      end
    end
    if (rst_n && req_if.valid && req_if.ready) begin
      if (fixed_valid) sbox_bytes_due.push_back(fixed_byte);
      else sbox_bytes_due.push_back(aes_substitute(req_if.action, req_if.data_in));
    end
  end

  always @(posedge clk) begin
    if ((req_if.valid && req_if.ready) || (sub_if.valid && sub_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    clk            = 1'b0;
    rst_n          = 1'b0;
    req_if.valid   = 1'b0;
    req_if.action  = ACT_FWD;
    req_if.data_in = 8'h00;
    sub_if.ready   = 1'b0;
    fixed_valid    = 1'b0;
    fixed_byte     = 8'h00;
    send_gap_pct   = 31;
    stall_pct      = 61;
    mismatches     = 0;
    quiet_cycles   = 0;

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int r = 0; r < N_ROWS; r++) begin
      offer_request(DIRECTED[r].act, DIRECTED[r].din, DIRECTED[r].fixed, DIRECTED[r].want);
    end

    // three idle patterns: sender light, then swapped, then none
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_gap_pct = 61;
        stall_pct    = 31;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_gap_pct = 0;
        stall_pct    = 0;
      end
      offer_request(1'($urandom_range(1)), 8'($urandom_range(255)), 1'b0, 8'h00);
    end
    req_if.valid <= 1'b0;

    // last request is logged on the edge it was accepted
    @(posedge clk);
    while (sbox_bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
